FILE: hw/rtl/mvcc_pkg.sv
package mvcc_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_VOLUME  = 2'd0;
    localparam logic [1:0] REG_AMPLIFY = 2'd1;
    localparam logic [1:0] REG_MODE    = 2'd2;

    localparam logic [7:0]  UNITY_GAIN   = 8'd128;
    localparam logic [7:0]  VOLUME_RESET = 8'd128;
    localparam logic [3:0]  MODE_RESET   = 4'd3;
    localparam logic [15:0] SAT_MIN      = 16'h8000;
    localparam logic [15:0] SAT_MAX      = 16'h7fff;
    localparam logic [7:0]  FLIP8        = 8'h80;
    localparam logic [15:0] FLIP16       = 16'h8000;
    localparam logic [15:0] FLIP8_PAIR   = 16'h8080;
    localparam logic [31:0] FLIP16_PAIR  = 32'h80008000;

    // Output format codes
    typedef enum logic [3:0] {
        MODE_U8      = 4'd0,
        MODE_S8      = 4'd1,
        MODE_U16     = 4'd2,
        MODE_S16     = 4'd3,
        MODE_U8_DUP  = 4'd4,
        MODE_S8_DUP  = 4'd5,
        MODE_U16_DUP = 4'd6,
        MODE_S16_DUP = 4'd7,
        MODE_U8_ST   = 4'd8,
        MODE_S8_ST   = 4'd9,
        MODE_U16_ST  = 4'd10,
        MODE_S16_ST  = 4'd11
    } out_mode_t;

    // Partial products of one channel
    typedef struct packed {
        logic [15:0]        p0;
        logic [15:0]        p1;
        logic signed [16:0] p2;
        logic signed [31:0] raw;
    } chan_prod_t;

    typedef struct packed {
        chan_prod_t left;
        chan_prod_t right;
        logic       block_end;
    } stage1_t;

    typedef struct packed {
        logic signed [31:0] left;
        logic signed [31:0] right;
        logic               block_end;
    } stage2_t;

    typedef struct packed {
        logic [15:0] left;
        logic [15:0] right;
        logic        block_end;
    } stage3_t;

    typedef struct packed {
        logic [63:0] data;
        logic [3:0]  count;
    } pack_t;

    // Clamp a signed 32-bit value to a signed 16-bit sample
    function automatic logic [15:0] sat16(logic signed [31:0] s);
        logic [15:0] r;
        if (s[31] && (s[30:15] != 16'hffff)) begin
            r = SAT_MIN;
        end else if (!s[31] && (s[30:15] != 16'h0000)) begin
            r = SAT_MAX;
        end else begin
            r = s[15:0];
        end
        return r;
    endfunction

    // Pack one sample pair into the selected output format
    function automatic pack_t pack_sample(logic [3:0] mode, logic [15:0] wl, logic [15:0] wr);
        pack_t       r;
        logic [7:0]  hl;
        logic [7:0]  hr;
        logic [15:0] pair16;
        logic [31:0] pair32;
        hl = wl[15:8];
        hr = wr[15:8];
        pair16 = 16'h0000;
        pair32 = 32'h0;
        r.data = 64'h0;
        r.count = 4'd2;
        case (mode)
            MODE_U8:
            begin
                r.data = {56'h0, hl ^ FLIP8};
                r.count = 4'd1;
            end
            MODE_S8:
            begin
                r.data = {56'h0, hl};
                r.count = 4'd1;
            end
            MODE_U16:
            begin
                r.data = {48'h0, wl ^ FLIP16};
                r.count = 4'd2;
            end
            MODE_U8_DUP:
            begin
                r.data = {48'h0, {hl, hl} ^ FLIP8_PAIR};
                r.count = 4'd2;
            end
            MODE_S8_DUP:
            begin
                r.data = {48'h0, hl, hl};
                r.count = 4'd2;
            end
            MODE_U16_DUP:
            begin
                pair16 = wl ^ FLIP16;
                r.data = {32'h0, pair16, pair16};
                r.count = 4'd4;
            end
            MODE_S16_DUP:
            begin
                r.data = {32'h0, wl, wl};
                r.count = 4'd4;
            end
            MODE_U8_ST:
            begin
                pair16 = {hr, hl} ^ FLIP8_PAIR;
                r.data = {32'h0, pair16, pair16};
                r.count = 4'd4;
            end
            MODE_S8_ST:
            begin
                pair16 = {hr, hl};
                r.data = {32'h0, pair16, pair16};
                r.count = 4'd4;
            end
            MODE_U16_ST:
            begin
                pair32 = {wr, wl} ^ FLIP16_PAIR;
                r.data = {pair32, pair32};
                r.count = 4'd8;
            end
            MODE_S16_ST:
            begin
                pair32 = {wr, wl};
                r.data = {pair32, pair32};
                r.count = 4'd8;
            end
            default:
            begin
                // s16, also for codes above the stereo formats
                r.data = {48'h0, wl};
                r.count = 4'd2;
            end
        endcase
        return r;
    endfunction

endpackage

FILE: hw/rtl/mix_volume_clip_convert_top.sv
// Channel   Handshake              Payload
// mix       mix_valid/mix_ready    left_mix, right_mix, block_end
// pack      pack_valid/pack_ready  packed_data, byte_count, block_end_out
// cfg       cfg_valid/cfg_ready    cfg_index, cfg_data
//
// Four register stages: byte products, scaled sum, saturation, packing.
// One request enters per cycle while mix_ready is high; pack_valid marks stage 4 full.
// Reset clears the stage valid bits and loads volume 128, scaling on, s16 format.
// A stall on pack_ready holds the run of full stages ending at stage 4; the rest keep moving.
// cfg_ready is always high; write registers only while the pipeline is empty.
module mix_volume_clip_convert_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               mix_valid,
    output logic               mix_ready,
    input  logic signed [31:0] left_mix,
    input  logic signed [31:0] right_mix,
    input  logic               block_end,
    output logic               pack_valid,
    input  logic               pack_ready,
    output logic [63:0]        packed_data,
    output logic [3:0]         byte_count,
    output logic               block_end_out,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_data
);

    logic [7:0] volume_reg;
    logic       amplify_enable_reg;
    logic [3:0] out_mode_reg;

    logic [3:0] valid_reg;
    logic [3:0] move;

    mvcc_pkg::stage1_t s1_reg;
    mvcc_pkg::stage1_t s1_next;
    mvcc_pkg::stage2_t s2_reg;
    mvcc_pkg::stage2_t s2_next;
    mvcc_pkg::stage3_t s3_reg;
    mvcc_pkg::stage3_t s3_next;
    mvcc_pkg::pack_t   s4_reg;
    mvcc_pkg::pack_t   s4_next;
    logic              s4_end_reg;

    logic [7:0]         gain;
    logic signed [8:0]  gain_s;
    logic signed [25:0] sum_l;
    logic signed [25:0] sum_r;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            volume_reg         <= mvcc_pkg::VOLUME_RESET;
            amplify_enable_reg <= 1'b1;
            out_mode_reg       <= mvcc_pkg::MODE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                mvcc_pkg::REG_VOLUME:  volume_reg <= cfg_data;
                mvcc_pkg::REG_AMPLIFY: amplify_enable_reg <= cfg_data[0];
                mvcc_pkg::REG_MODE:    out_mode_reg <= cfg_data[3:0];
                default:               ;
            endcase
        end
    end

    // Stage advance: a stage loads when it is empty or its successor moves
    assign move[3]   = !valid_reg[3] || pack_ready;
    assign move[2]   = !valid_reg[2] || move[3];
    assign move[1]   = !valid_reg[1] || move[2];
    assign move[0]   = !valid_reg[0] || move[1];
    assign mix_ready = move[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 4'b0000;
        end
        else
        begin
            if (move[0]) valid_reg[0] <= mix_valid;
            if (move[1]) valid_reg[1] <= valid_reg[0];
            if (move[2]) valid_reg[2] <= valid_reg[1];
            if (move[3]) valid_reg[3] <= valid_reg[2];
        end
    end

    // Stage 1: byte products with the clamped gain
    assign gain   = (volume_reg > mvcc_pkg::UNITY_GAIN) ? mvcc_pkg::UNITY_GAIN : volume_reg;
    assign gain_s = $signed({1'b0, gain});

    always_comb
    begin
        s1_next.left.p0  = left_mix[7:0] * gain;
        s1_next.left.p1  = left_mix[15:8] * gain;
        s1_next.left.p2  = 17'($signed(left_mix[23:16]) * gain_s);
        s1_next.left.raw = left_mix;
        s1_next.right.p0  = right_mix[7:0] * gain;
        s1_next.right.p1  = right_mix[15:8] * gain;
        s1_next.right.p2  = 17'($signed(right_mix[23:16]) * gain_s);
        s1_next.right.raw = right_mix;
        s1_next.block_end = block_end;
    end

    // Stage 2: weighted sum, or bypass of the raw word
    assign sum_l = $signed({s1_reg.left.p2, 9'b0})
                 + $signed({9'b0, s1_reg.left.p1, 1'b0})
                 + $signed({17'b0, s1_reg.left.p0[15:7]});
    assign sum_r = $signed({s1_reg.right.p2, 9'b0})
                 + $signed({9'b0, s1_reg.right.p1, 1'b0})
                 + $signed({17'b0, s1_reg.right.p0[15:7]});

    always_comb
    begin
        s2_next.left  = amplify_enable_reg ? {{6{sum_l[25]}}, sum_l} : s1_reg.left.raw;
        s2_next.right = amplify_enable_reg ? {{6{sum_r[25]}}, sum_r} : s1_reg.right.raw;
        s2_next.block_end = s1_reg.block_end;
    end

    // Stage 3: saturate to 16 bits
    always_comb
    begin
        s3_next.left      = mvcc_pkg::sat16(s2_reg.left);
        s3_next.right     = mvcc_pkg::sat16(s2_reg.right);
        s3_next.block_end = s2_reg.block_end;
    end

    // Stage 4: pack into the output format
    assign s4_next = mvcc_pkg::pack_sample(out_mode_reg, s3_reg.left, s3_reg.right);

    always_ff @(posedge clk)
    begin
        if (move[0]) s1_reg <= s1_next;
        if (move[1]) s2_reg <= s2_next;
        if (move[2]) s3_reg <= s3_next;
        if (move[3])
        begin
            s4_reg     <= s4_next;
            s4_end_reg <= s3_reg.block_end;
        end
    end

    assign pack_valid    = valid_reg[3];
    assign packed_data   = s4_reg.data;
    assign byte_count    = s4_reg.count;
    assign block_end_out = s4_end_reg;

    // Checks
    a_count_legal: assert property (@(posedge clk) disable iff (!rst_n)
        pack_valid |-> (byte_count == 4'd1 || byte_count == 4'd2 ||
                        byte_count == 4'd4 || byte_count == 4'd8))
        else $error("illegal byte count");

    a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (pack_valid && byte_count != 4'd8) |-> (packed_data[63:32] == 32'h0) &&
        (byte_count == 4'd4 || packed_data[31:16] == 16'h0) &&
        (byte_count != 4'd1 || packed_data[15:8] == 8'h0))
        else $error("bytes beyond byte count are not zero");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[2] && valid_reg[3] && !pack_ready) |=> (valid_reg[2] && valid_reg[3]))
        else $error("request dropped during output stall");

    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !mix_ready |-> (valid_reg == 4'b1111 && !pack_ready))
        else $error("input stalled with room in the pipeline");

endmodule
